// ===== src/sbv_pkg.sv =====
// shared types and constants for the skinned vertex blend block
package sbv_pkg;

  localparam int LANES = 4;
  localparam int ELEMS = 4;
  localparam logic [1:0] LAST_ROW = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SKIN = 1'b1;

  localparam logic REG_BONE_COUNT = 1'b0;
  localparam logic [6:0] BONE_COUNT_RESET = 7'd1;

  typedef struct packed {
    logic                  valid;
    logic [1:0]            row;
    logic                  last;
    logic [LANES-1:0]      use_lane;
    logic [LANES-1:0][12:0] weight;
    logic [2:0][15:0]      vec;
  } stage_t;

endpackage

// ===== src/sbv_lane.sv =====
// one influence lane: bone matrix store copy, row read and weight products
module sbv_lane import sbv_pkg::*; #(
  parameter int MAX_BONES = 64,
  parameter int RW = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [RW-1:0]     wr_row,
  input  logic [1:0]        wr_col,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [RW-1:0]     rd_row,
  input  logic [12:0]       weight,
  output logic [ELEMS-1:0][31:0] term
);

  localparam int DEPTH = MAX_BONES * 4;

  logic [31:0] mem [DEPTH][ELEMS];
  logic [ELEMS-1:0][31:0] rd;
  logic [12:0] w_q;
  logic signed [45:0] prod [ELEMS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_col] <= wr_data;
    end
    if (rd_en) begin
      for (int e = 0; e < ELEMS; e++) begin
        rd[e] <= mem[rd_row][e];
      end
      w_q <= weight;
    end
  end

  always_comb begin
    for (int e = 0; e < ELEMS; e++) begin
      prod[e] = $signed(rd[e]) * $signed({1'b0, w_q});
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int e = 0; e < ELEMS; e++) begin
        term[e] <= prod[e][43:12];
      end
    end
  end

endmodule

// ===== src/sbv_merge.sv =====
// lane merge: blended matrix row, row times vertex, output packing
module sbv_merge import sbv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  stage_t s2,
  input  logic [LANES-1:0][ELEMS-1:0][31:0] lane_term,
  output logic   res_valid,
  output logic [29:0] res_data
);

  stage_t s3;
  stage_t s4;
  logic [ELEMS-1:0][31:0] blend;
  logic [ELEMS-1:0][15:0] rp;
  logic [31:0] blend_next [ELEMS];
  logic signed [47:0] mul [3];
  logic [15:0] rowsum;
  logic [9:0] x_q;
  logic [9:0] y_q;

  always_comb begin
    for (int e = 0; e < ELEMS; e++) begin
      blend_next[e] = '0;
      for (int i = 0; i < LANES; i++) begin
        if (s2.use_lane[i]) begin
          blend_next[e] = blend_next[e] + lane_term[i][e];
        end
      end
    end
    for (int e = 0; e < 3; e++) begin
      mul[e] = $signed(blend[e]) * $signed(s3.vec[e]);
    end
    rowsum = rp[0] + rp[1] + rp[2] + rp[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
    end else if (adv) begin
      s3.valid <= s2.valid;
      s4.valid <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3.row <= s2.row;
      s3.last <= s2.last;
      s3.use_lane <= s2.use_lane;
      s3.weight <= s2.weight;
      s3.vec <= s2.vec;
      s4.row <= s3.row;
      s4.last <= s3.last;
      s4.use_lane <= s3.use_lane;
      s4.weight <= s3.weight;
      s4.vec <= s3.vec;
      for (int e = 0; e < ELEMS; e++) begin
        blend[e] <= blend_next[e];
      end
      for (int e = 0; e < 3; e++) begin
        rp[e] <= mul[e][27:12];
      end
      rp[3] <= blend[3][15:0];
      if (s4.valid && s4.row == 2'd0) begin
        x_q <= rowsum[15:6];
      end
      if (s4.valid && s4.row == 2'd1) begin
        y_q <= rowsum[15:6];
      end
    end
  end

  assign res_valid = s4.valid && s4.last;
  assign res_data = {rowsum[15:6], y_q, x_q};

endmodule

// ===== src/skinned_vertex_blend.sv =====
// top level: command intake, row sequencer, config register, output register
//
// Two valid/ready channels. An input beat with cmd 0 writes one 32-bit word
// of a bone matrix (bone*16 + row*4 + column) into every lane's copy of the
// bone store and gives no result. A beat with cmd 1 skins one vertex and
// gives exactly one output beat. Four lanes, one per influence, each read
// one matrix row per cycle from their store copy while the output does not
// stall; the merge stage sums the weighted rows and forms the dot product
// with the vertex. Only rows 0 to 2 are read, so a vertex holds the sequencer
// for three rows and a new beat is taken only in its last row; while idle
// and not stalled, the block takes one load every cycle.
// The store is undefined after reset and must be loaded before use.
// Reset empties the pipeline and sets bone_count to 1.
// When the receiver stalls, the output register holds its beat and the
// whole pipeline freezes; input ready drops until it drains.
// bone_count is written through the APB-style port at byte address 0.
module skinned_vertex_blend import sbv_pkg::*; #(
  parameter int MAX_BONES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid,
  output logic        ready,
  input  logic        cmd,
  input  logic [9:0]  load_address,
  input  logic [31:0] load_value,
  input  logic [29:0] position_in,
  input  logic [5:0]  bone_a,
  input  logic [5:0]  bone_b,
  input  logic [5:0]  bone_c,
  input  logic [5:0]  bone_d,
  input  logic [12:0] weight_a,
  input  logic [12:0] weight_b,
  input  logic [12:0] weight_c,
  input  logic [12:0] weight_d,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] position_out
);

  localparam int BW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int RW = BW + 2;
  localparam int STORE_WORDS = MAX_BONES * 16;

  logic [6:0] bone_count;
  logic adv;
  logic accept;
  logic busy;
  logic [1:0] row;
  logic [LANES-1:0][7:0] bone_q;
  logic [LANES-1:0][7:0] bone_in;
  logic [LANES-1:0][12:0] weight_in;
  logic [LANES-1:0] use_in;
  logic [LANES-1:0] use_q;
  logic [LANES-1:0][12:0] weight_q;
  logic [2:0][15:0] vec_q;
  stage_t ctx;
  stage_t s1;
  stage_t s2;
  logic wr_en;
  logic [7:0] wr_bone;
  logic [LANES-1:0][ELEMS-1:0][31:0] lane_term;
  logic res_valid;
  logic [29:0] res_data;

  assign pready = 1'b1;
  assign prdata = {25'd0, bone_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      bone_count <= BONE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_BONE_COUNT) begin
      bone_count <= pwdata[6:0];
    end
  end

  assign adv = !out_valid || out_ready;
  assign ready = adv && (!busy || row == LAST_ROW);
  assign accept = valid && ready;

  assign bone_in = {{2'b0, bone_d}, {2'b0, bone_c}, {2'b0, bone_b}, {2'b0, bone_a}};
  assign weight_in = {weight_d, weight_c, weight_b, weight_a};

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      use_in[i] = (32'(bone_count) > i) && (32'(bone_in[i]) < MAX_BONES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row <= 2'd0;
    end else if (adv) begin
      if (accept && cmd == CMD_SKIN) begin
        busy <= 1'b1;
        row <= 2'd0;
      end else if (busy) begin
        if (row == LAST_ROW) begin
          busy <= 1'b0;
        end else begin
          row <= row + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_SKIN) begin
      bone_q <= bone_in;
      use_q <= use_in;
      weight_q <= weight_in;
      vec_q[0] <= {position_in[9:0], 6'd0};
      vec_q[1] <= {position_in[19:10], 6'd0};
      vec_q[2] <= {position_in[29:20], 6'd0};
    end
  end

  assign ctx = '{valid: busy, row: row, last: (row == LAST_ROW), use_lane: use_q,
                 weight: weight_q, vec: vec_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else if (adv) begin
      s1.valid <= ctx.valid;
      s2.valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.row <= ctx.row;
      s1.last <= ctx.last;
      s1.use_lane <= ctx.use_lane;
      s1.weight <= ctx.weight;
      s1.vec <= ctx.vec;
      s2.row <= s1.row;
      s2.last <= s1.last;
      s2.use_lane <= s1.use_lane;
      s2.weight <= s1.weight;
      s2.vec <= s1.vec;
    end
  end

  assign wr_en = accept && cmd == CMD_LOAD && (32'(load_address) < STORE_WORDS);
  assign wr_bone = {2'b0, load_address[9:4]};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sbv_lane #(
      .MAX_BONES(MAX_BONES),
      .RW(RW)
    ) u_lane (
      .clk(clk),
      .wr_en(wr_en),
      .wr_row({wr_bone[BW-1:0], load_address[3:2]}),
      .wr_col(load_address[1:0]),
      .wr_data(load_value),
      .rd_en(adv),
      .rd_row({bone_q[i][BW-1:0], row}),
      .weight(ctx.weight[i]),
      .term(lane_term[i])
    );
  end

  sbv_merge u_merge (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .s2(s2),
    .lane_term(lane_term),
    .res_valid(res_valid),
    .res_data(res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      position_out <= res_data;
    end
  end

endmodule

// ===== tb/skinned_vertex_blend_test.sv =====
// testbench for the skinned vertex blend block: predicted skinning results checked beat by beat
module skinned_vertex_blend_test;
  import sbv_pkg::*;

  localparam int STORE_WORDS = 64 * 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        valid = 1'b0;
  logic        ready;
  logic        cmd = CMD_LOAD;
  logic [9:0]  load_address = '0;
  logic [31:0] load_value = '0;
  logic [29:0] position_in = '0;
  logic [5:0]  bone_a = '0, bone_b = '0, bone_c = '0, bone_d = '0;
  logic [12:0] weight_a = '0, weight_b = '0, weight_c = '0, weight_d = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [29:0] position_out;

  logic [31:0] matrix_words [STORE_WORDS];
  logic [6:0]  bones_used;
  logic [29:0] expected_positions [$];
  int          mismatches = 0;
  int          long_hold = 0;
  bit          stall_enable = 1'b1;

  always #10 clk = ~clk;

  skinned_vertex_blend dut (.*);

  function automatic logic signed [63:0] mul_floor(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> 12;
  endfunction

  function automatic logic [29:0] skin_vertex(logic [29:0] pos, logic [5:0] bones [4],
                                              logic [12:0] weights [4]);
    logic [31:0] blend [16];
    logic signed [31:0] vec [4];
    logic signed [63:0] acc;
    logic signed [31:0] row;
    logic [29:0] packed_pos;
    int uses;
    packed_pos = '0;
    foreach (blend[e]) blend[e] = '0;
    uses = bones_used < 4 ? bones_used : 4;
    for (int i = 0; i < uses; i++) begin
      if (weights[i] != 0) begin
        for (int e = 0; e < 16; e++)
          blend[e] = blend[e] + 32'(mul_floor(matrix_words[{bones[i], 4'(e)}],
                                              {19'd0, weights[i]}));
      end
    end
    for (int c = 0; c < 3; c++)
      vec[c] = 32'(signed'(pos[10*c +: 10])) <<< 6;
    vec[3] = 32'd4096;
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int e = 0; e < 4; e++) acc += mul_floor(blend[r*4+e], vec[e]);
      row = acc[31:0];
      packed_pos[10*r +: 10] = 10'(row >>> 6);
    end
    return packed_pos;
  endfunction

  task automatic write_bone_count(logic [6:0] count);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * REG_BONE_COUNT); pwdata <= {25'd0, count};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    bones_used = count;
  endtask

  task automatic send_beat(logic c, logic [9:0] addr, logic [31:0] value,
                           logic [29:0] pos, logic [5:0] bones [4],
                           logic [12:0] weights [4]);
    valid <= 1'b1; cmd <= c; load_address <= addr; load_value <= value;
    position_in <= pos;
    bone_a <= bones[0]; bone_b <= bones[1]; bone_c <= bones[2]; bone_d <= bones[3];
    weight_a <= weights[0]; weight_b <= weights[1];
    weight_c <= weights[2]; weight_d <= weights[3];
    do @(posedge clk); while (!ready);
    if (c == CMD_LOAD) begin
      matrix_words[addr] = value;
    end else begin
      expected_positions.push_back(skin_vertex(pos, bones, weights));
    end
  endtask

  task automatic idle_gap();
    valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  task automatic load_word(logic [9:0] addr, logic [31:0] value);
    logic [5:0] bones [4] = '{default: '0};
    logic [12:0] weights [4] = '{default: '0};
    send_beat(CMD_LOAD, addr, value, 30'($urandom), bones, weights);
  endtask

  task automatic skin(logic [29:0] pos, logic [5:0] bones [4], logic [12:0] weights [4]);
    send_beat(CMD_SKIN, 10'($urandom), $urandom, pos, bones, weights);
  endtask

  task automatic random_vertex(int bone_limit, bit big);
    logic [5:0] bones [4];
    logic [12:0] weights [4];
    for (int i = 0; i < 4; i++) begin
      bones[i] = 6'($urandom_range(0, bone_limit - 1));
      case ($urandom_range(0, 5))
        0: weights[i] = '0;
        1: weights[i] = 13'd4096;
        2: weights[i] = 13'($urandom);
        default: weights[i] = 13'($urandom_range(0, 4096));
      endcase
    end
    if (big) begin
      for (int i = 0; i < 4; i++) weights[i] = 13'($urandom);
    end
    skin(30'($urandom), bones, weights);
  endtask

  task automatic drain();
    valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_matrix_word(int bone_limit, bit wide);
    logic [9:0] addr;
    addr = 10'($urandom_range(0, bone_limit * 16 - 1));
    if (wide) load_word(addr, $urandom);
    else load_word(addr, 32'($signed($urandom_range(0, 16384)) - 8192));
  endtask

  task automatic test_directed();
    logic [5:0] bones [4];
    logic [12:0] weights [4];
    for (int e = 0; e < 16; e++) load_word(10'(e), (e % 5 == 0) ? 32'd4096 : 32'd0);
    for (int e = 0; e < 16; e++) load_word(10'(1008 + e), 32'h8000_0000 + e);
    load_word(10'd16, 32'h7fff_ffff);
    load_word(10'd1023, 32'hffff_ffff);
    bones = '{6'd0, 6'd63, 6'd0, 6'd63};
    weights = '{13'd4096, 13'd0, 13'd0, 13'd0};
    skin(30'h0000_0000, bones, weights);
    skin(30'h3fff_ffff, bones, weights);
    skin({10'h200, 10'h1ff, 10'h200}, bones, weights);
    weights = '{13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff};
    skin({10'h1ff, 10'h200, 10'h155}, bones, weights);
    drain();
    write_bone_count(7'd0);
    skin(30'h2aa_aaaa, bones, weights);
    drain();
    write_bone_count(7'd4);
    skin(30'h155_5555, bones, weights);
    bones = '{6'd63, 6'd63, 6'd0, 6'd0};
    skin(30'h3ff_03ff, bones, weights);
    drain();
  endtask

  task automatic test_random(int count, int bone_limit);
    int burst;
    int sent = 0;
    while (sent < count) begin
      burst = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 10);
      for (int k = 0; k < burst && sent < count; k++) begin
        if ($urandom_range(0, 2) == 0) random_matrix_word(bone_limit, $urandom_range(0, 3) == 0);
        else random_vertex(bone_limit, $urandom_range(0, 9) == 0);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    drain();
  endtask

  task automatic fill_store();
    for (int a = 0; a < STORE_WORDS; a++)
      load_word(10'(a), 32'($signed($urandom_range(0, 16384)) - 8192));
    drain();
  endtask

  task automatic test_backpressure();
    long_hold = 200;
    for (int k = 0; k < 40; k++) random_vertex(64, 1'b0);
    drain();
  endtask

  always @(posedge clk) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ready <= 1'b0;
    end else if (rst || !stall_enable) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 63) < 8);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat position_out=%h", position_out);
      end else begin
        if (position_out !== expected_positions[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("position_out mismatch: expected %h actual %h",
                     expected_positions[0], position_out);
        end
        void'(expected_positions.pop_front());
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bones_used = BONE_COUNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fill_store();
    test_directed();
    write_bone_count(7'd64);
    test_random(250, 64);
    write_bone_count(7'd2);
    test_random(150, 64);
    write_bone_count(7'd127);
    test_random(150, 4);
    write_bone_count(7'd1);
    test_random(100, 64);
    write_bone_count(7'd3);
    test_backpressure();
    stall_enable = 1'b0;
    test_random(100, 64);
    stall_enable = 1'b1;
    if (mismatches == 0 && expected_positions.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
